[src/u2u8_pkg.sv]
// Shared types and constants for the UTF-16 to UTF-8 window transcoder.
// No dependencies; every other file depends on this package.
package u2u8_pkg;

  localparam int unsigned CNT_W = 14;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CNT_W-1:0] WINDOW_RST = 14'd12288;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BYTES = 2'd1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_LONE_LOW  = 2'd1,
    ST_LONE_HIGH = 2'd2
  } status_e;

  // One queue entry: the bytes of one code point, plus an optional closing.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            close;
    status_e         status;
  } cmd_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             end_of_string;
    logic [1:0]       status;
    logic [CNT_W-1:0] bytes_delivered;
    logic [CNT_W-1:0] total_length;
  } result_t;

endpackage

[src/u2u8_if.sv]
// Channel interfaces: code unit input, result output, configuration write.
// Depends on u2u8_pkg for field widths.
interface u2u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;
  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink (input valid, input code_unit, input last_unit, output ready);
endinterface

interface u2u8_out_if;
  logic                       valid;
  logic                       ready;
  logic [7:0]                 out_byte;
  logic                       byte_valid;
  logic                       end_of_string;
  logic [1:0]                 status;
  logic [u2u8_pkg::CNT_W-1:0] bytes_delivered;
  logic [u2u8_pkg::CNT_W-1:0] total_length;
  modport source (output valid, output out_byte, output byte_valid,
                  output end_of_string, output status, output bytes_delivered,
                  output total_length, input ready);
  modport sink (input valid, input out_byte, input byte_valid,
                input end_of_string, input status, input bytes_delivered,
                input total_length, output ready);
endinterface

interface u2u8_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [u2u8_pkg::CFG_IDX_W-1:0] index;
  logic [u2u8_pkg::CNT_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[src/u2u8_front.sv]
// Front end: surrogate pairing, error drop and UTF-8 encoding into queue entries.
// Depends on u2u8_pkg.
module u2u8_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [15:0]    code_unit_i,
  input  logic           last_unit_i,
  output logic           in_ready_o,
  output logic           cmd_valid_o,
  output u2u8_pkg::cmd_t cmd_o,
  input  logic           cmd_ready_i
);
  import u2u8_pkg::*;

  logic        pend_q, pend_d;
  logic [9:0]  hbits_q, hbits_d;
  logic        drop_q, drop_d;
  logic        accept, is_high, is_low;
  logic [20:0] cp;
  cmd_t        cmd;

  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i && cmd_ready_i;
  assign is_high    = code_unit_i[15:10] == 6'b110110;
  assign is_low     = code_unit_i[15:10] == 6'b110111;
  assign cp         = {1'b0, hbits_q, code_unit_i[9:0]} + 21'h10000;

  always_comb begin
    pend_d      = pend_q;
    hbits_d     = hbits_q;
    drop_d      = drop_q;
    cmd.bytes   = '0;
    cmd.nbytes  = 3'd0;
    cmd.close   = last_unit_i;
    cmd.status  = ST_OK;
    if (drop_q) begin
      cmd.close = 1'b0;
      if (last_unit_i) drop_d = 1'b0;
    end else if (pend_q) begin
      pend_d  = 1'b0;
      hbits_d = '0;
      if (!is_low) begin
        cmd.close  = 1'b1;
        cmd.status = ST_LONE_HIGH;
        drop_d     = !last_unit_i;
      end else begin
        cmd.nbytes   = 3'd4;
        cmd.bytes[0] = {5'b11110, cp[20:18]};
        cmd.bytes[1] = {2'b10, cp[17:12]};
        cmd.bytes[2] = {2'b10, cp[11:6]};
        cmd.bytes[3] = {2'b10, cp[5:0]};
      end
    end else if (is_low) begin
      cmd.close  = 1'b1;
      cmd.status = ST_LONE_LOW;
      drop_d     = !last_unit_i;
    end else if (is_high) begin
      if (last_unit_i) begin
        cmd.status = ST_LONE_HIGH;
      end else begin
        pend_d  = 1'b1;
        hbits_d = code_unit_i[9:0];
      end
    end else if (code_unit_i[15:7] == '0) begin
      cmd.nbytes   = 3'd1;
      cmd.bytes[0] = code_unit_i[7:0];
    end else if (code_unit_i[15:11] == '0) begin
      cmd.nbytes   = 3'd2;
      cmd.bytes[0] = {3'b110, code_unit_i[10:6]};
      cmd.bytes[1] = {2'b10, code_unit_i[5:0]};
    end else begin
      cmd.nbytes   = 3'd3;
      cmd.bytes[0] = {4'b1110, code_unit_i[15:12]};
      cmd.bytes[1] = {2'b10, code_unit_i[11:6]};
      cmd.bytes[2] = {2'b10, code_unit_i[5:0]};
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = accept && ((cmd.nbytes != 3'd0) || cmd.close);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      hbits_q <= '0;
      drop_q  <= 1'b0;
    end else if (accept) begin
      pend_q  <= pend_d;
      hbits_q <= hbits_d;
      drop_q  <= drop_d;
    end
  end

endmodule

[src/u2u8_fifo.sv]
// Short queue of encoded entries between front and back end.
// Depends on u2u8_pkg for the entry type.
module u2u8_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  u2u8_pkg::cmd_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output u2u8_pkg::cmd_t rd_data_o
);
  import u2u8_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;

  assign wr_ready_o = cnt_q != FULL_CNT;
  assign rd_valid_o = cnt_q != '0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
      if (pop)  rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[src/u2u8_back.sv]
// Back end: walks the bytes of each entry, applies the byte window, emits
// byte and closing results through an output register. Depends on u2u8_pkg.
module u2u8_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cmd_valid_i,
  input  u2u8_pkg::cmd_t          cmd_i,
  output logic                    cmd_pop_o,
  input  logic [u2u8_pkg::CNT_W-1:0] skip_i,
  input  logic [u2u8_pkg::CNT_W-1:0] window_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output u2u8_pkg::result_t       res_o
);
  import u2u8_pkg::*;

  logic [2:0]       idx_q, idx_d;
  logic [CNT_W-1:0] pos_q, pos_d, dlv_q, dlv_d;
  logic             vld_q, vld_d;
  result_t          res_q, res_d;
  logic             step, in_bytes, done, pass;

  assign step     = cmd_valid_i && (!vld_q || res_ready_i);
  assign in_bytes = idx_q < cmd_i.nbytes;
  assign pass     = (pos_q >= skip_i) && (dlv_q < window_i);
  assign done     = in_bytes ? ((idx_q + 3'd1 == cmd_i.nbytes) && !cmd_i.close) : 1'b1;
  assign cmd_pop_o = step && done;

  always_comb begin
    idx_d = idx_q;
    pos_d = pos_q;
    dlv_d = dlv_q;
    vld_d = vld_q && !res_ready_i;
    res_d = res_q;
    if (step) begin
      idx_d = done ? 3'd0 : idx_q + 3'd1;
      if (in_bytes) begin
        if (pos_q != CNT_MAX) pos_d = pos_q + 1'b1;
        if (pass) begin
          if (dlv_q != CNT_MAX) dlv_d = dlv_q + 1'b1;
          vld_d               = 1'b1;
          res_d               = '0;
          res_d.out_byte      = cmd_i.bytes[idx_q[1:0]];
          res_d.byte_valid    = 1'b1;
        end
      end else begin
        // closing result; string counters restart
        vld_d                 = 1'b1;
        res_d                 = '0;
        res_d.end_of_string   = 1'b1;
        res_d.status          = cmd_i.status;
        res_d.bytes_delivered = dlv_q;
        res_d.total_length    = (cmd_i.status == ST_OK) ? pos_q : '0;
        pos_d                 = '0;
        dlv_d                 = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      pos_q <= '0;
      dlv_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      pos_q <= pos_d;
      dlv_q <= dlv_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

[src/utf16_to_utf8_window.sv]
// Top level of the UTF-16 to UTF-8 window transcoder: config registers and
// front / queue / back wiring. Depends on u2u8_pkg, u2u8_if and submodules.
//
//  channel  dir  transfer carries
//  -------  ---  ----------------------------------------------------------
//  in_i     in   code_unit, last_unit
//  out_o    out  out_byte, byte_valid, end_of_string, status,
//                bytes_delivered, total_length
//  cfg_i    in   index (0 skip_bytes, 1 window_bytes, others ignored), data
//
// The back end retires one step per cycle unless the output stalls; each UTF-8
// byte of a code point is a step (1-3 for a BMP unit, 4 for a surrogate pair),
// and a closing result another. Sustained rate is set by that walk; the front end
// takes a unit every cycle while the queue has room, so a high surrogate or a
// dropped unit costs no back-end time. Reset (async, active low) clears all
// string state, empties the queue and loads skip_bytes 0, window_bytes 12288.
// A stalled output holds its register; the queue then fills and in_i.ready drops.
module utf16_to_utf8_window #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  u2u8_in_if.sink    in_i,
  u2u8_out_if.source out_o,
  u2u8_cfg_if.sink   cfg_i
);
  import u2u8_pkg::*;

  logic [CNT_W-1:0] skip_q, window_q;
  logic             fq_wr_valid, fq_wr_ready, fq_rd_valid, fq_pop;
  cmd_t             fq_wr_data, fq_rd_data;
  logic             res_valid;
  result_t          res;

  // Configuration: always ready, writes land directly.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q   <= '0;
      window_q <= WINDOW_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SKIP_BYTES:   skip_q   <= cfg_i.data;
        CFG_WINDOW_BYTES: window_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Front: pairing, error drop, encoding.
  u2u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .code_unit_i (in_i.code_unit),
    .last_unit_i (in_i.last_unit),
    .in_ready_o  (in_i.ready),
    .cmd_valid_o (fq_wr_valid),
    .cmd_o       (fq_wr_data),
    .cmd_ready_i (fq_wr_ready)
  );

  // Decoupling queue.
  u2u8_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_wr_valid),
    .wr_ready_o (fq_wr_ready),
    .wr_data_i  (fq_wr_data),
    .rd_valid_o (fq_rd_valid),
    .rd_ready_i (fq_pop),
    .rd_data_o  (fq_rd_data)
  );

  // Back: window, counters, output register.
  u2u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (fq_rd_valid),
    .cmd_i       (fq_rd_data),
    .cmd_pop_o   (fq_pop),
    .skip_i      (skip_q),
    .window_i    (window_q),
    .res_valid_o (res_valid),
    .res_ready_i (out_o.ready),
    .res_o       (res)
  );

  assign out_o.valid           = res_valid;
  assign out_o.out_byte        = res.out_byte;
  assign out_o.byte_valid      = res.byte_valid;
  assign out_o.end_of_string   = res.end_of_string;
  assign out_o.status          = res.status;
  assign out_o.bytes_delivered = res.bytes_delivered;
  assign out_o.total_length    = res.total_length;

endmodule
